/* design/piecewise_linear_score_accumulator_macros.svh */
// Assertion macros shared by the piecewise linear score accumulator RTL.
`ifndef PIECEWISE_LINEAR_SCORE_ACCUMULATOR_MACROS_SVH
`define PIECEWISE_LINEAR_SCORE_ACCUMULATOR_MACROS_SVH

// Same-cycle implication, checked outside of reset.
`define PLSA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("plsa same-cycle check failed");

// Next-cycle implication, checked outside of reset.
`define PLSA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("plsa next-cycle check failed");

`endif

/* design/plsa_pkg.sv */
// Package with the shared constants, types and codes of the score accumulator.
`default_nettype none

package plsa_pkg;

    localparam int MAX_POINTS = 6;
    localparam int PT_IDX_W   = $clog2(MAX_POINTS);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);

    localparam int DATA_W     = 32;
    localparam int POINT_W    = 64;
    localparam int COUNT_W    = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_POINT_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POINT_FIRST = 3'd1;

    // Divider: two quotient bits per cycle over a 64-bit dividend.
    localparam int DIV_NUM_W  = 64;
    localparam int DIV_DEN_W  = 32;
    localparam int DIV_STEPS  = 2;
    localparam int DIV_ITER   = DIV_NUM_W / DIV_STEPS;
    localparam int DIV_CNT_W  = $clog2(DIV_ITER);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_PAIR,
        ST_MUL,
        ST_START,
        ST_DIV,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic                     update;
        logic                     clear;
        logic signed [DATA_W-1:0] score;
    } t_acc_cmd;

endpackage

`default_nettype wire

/* design/plsa_if.sv */
// Valid/ready channel interfaces for sample input and score output.
`default_nettype none

interface plsa_in_if;
    logic                     valid;
    logic                     ready;
    logic signed [31:0]       sample_value;
    logic                     clear_total;

    modport source (output valid, output sample_value, output clear_total, input ready);
    modport sink   (input valid, input sample_value, input clear_total, output ready);
endinterface

interface plsa_out_if;
    logic                     valid;
    logic                     ready;
    logic signed [31:0]       score;
    logic                     segment_found;
    logic                     zero_span;
    logic signed [31:0]       running_sum;

    modport source (output valid, output score, output segment_found, output zero_span,
                    output running_sum, input ready);
    modport sink   (input valid, input score, input segment_found, input zero_span,
                    input running_sum, output ready);
endinterface

`default_nettype wire

/* design/plsa_div.sv */
// Iterative signed divider, two restoring quotient bits per cycle.
`default_nettype none

module plsa_div (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_start,
    input  wire logic signed [plsa_pkg::DIV_NUM_W-1:0] i_dividend,
    input  wire logic signed [plsa_pkg::DIV_DEN_W-1:0] i_divisor,
    output logic                                       o_done,
    output logic        [plsa_pkg::DATA_W-1:0]         o_quotient
);

    logic                              r_busy;
    logic                              r_done;
    logic [plsa_pkg::DIV_CNT_W-1:0]    r_cnt;
    logic [plsa_pkg::DIV_DEN_W-1:0]    r_rem;
    logic [plsa_pkg::DIV_NUM_W-1:0]    r_quo;
    logic [plsa_pkg::DIV_DEN_W-1:0]    r_den;
    logic                              r_neg;

    logic [plsa_pkg::DIV_DEN_W-1:0]    n_rem;
    logic [plsa_pkg::DIV_NUM_W-1:0]    n_quo;

    // Two dependent compare-and-subtract steps on the partial remainder.
    always_comb begin
        logic [plsa_pkg::DIV_DEN_W:0] trial;
        logic                         ge;
        n_rem = r_rem;
        n_quo = r_quo;
        for (int s = 0; s < plsa_pkg::DIV_STEPS; s++) begin
            trial = {n_rem, n_quo[plsa_pkg::DIV_NUM_W-1]};
            ge    = (trial >= {1'b0, r_den});
            n_rem = ge ? plsa_pkg::DIV_DEN_W'(trial - {1'b0, r_den})
                       : trial[plsa_pkg::DIV_DEN_W-1:0];
            n_quo = {n_quo[plsa_pkg::DIV_NUM_W-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == plsa_pkg::DIV_CNT_W'(plsa_pkg::DIV_ITER - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_cnt <= '0;
            r_rem <= '0;
            r_quo <= i_dividend[plsa_pkg::DIV_NUM_W-1] ? (~i_dividend + 1'b1) : i_dividend;
            r_den <= i_divisor[plsa_pkg::DIV_DEN_W-1] ? (~i_divisor + 1'b1) : i_divisor;
            r_neg <= i_dividend[plsa_pkg::DIV_NUM_W-1] ^ i_divisor[plsa_pkg::DIV_DEN_W-1];
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    // Only the low word of the quotient reaches the score.
    assign o_done     = r_done;
    assign o_quotient = r_neg ? (~r_quo[plsa_pkg::DATA_W-1:0] + 1'b1)
                              : r_quo[plsa_pkg::DATA_W-1:0];

endmodule

`default_nettype wire

/* design/plsa_acc.sv */
// Saturating signed running total of the scores.
`default_nettype none

module plsa_acc (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire plsa_pkg::t_acc_cmd                     i_cmd,
    output logic signed [plsa_pkg::DATA_W-1:0]          o_total_next
);

    logic signed [plsa_pkg::DATA_W-1:0] r_total;
    logic signed [plsa_pkg::DATA_W-1:0] base;
    logic        [plsa_pkg::DATA_W:0]   sum;

    assign base = i_cmd.clear ? '0 : r_total;
    assign sum  = {base[plsa_pkg::DATA_W-1], base}
                + {i_cmd.score[plsa_pkg::DATA_W-1], i_cmd.score};

    // The two top bits differ only when the add left the signed range.
    always_comb begin
        if (sum[plsa_pkg::DATA_W] != sum[plsa_pkg::DATA_W-1]) begin
            o_total_next = sum[plsa_pkg::DATA_W]
                ? {1'b1, {(plsa_pkg::DATA_W-1){1'b0}}}
                : {1'b0, {(plsa_pkg::DATA_W-1){1'b1}}};
        end else begin
            o_total_next = sum[plsa_pkg::DATA_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0;
        end else if (i_cmd.update) begin
            r_total <= o_total_next;
        end
    end

endmodule

`default_nettype wire

/* design/piecewise_linear_score_accumulator.sv */
// Top level of the piecewise linear score accumulator.
//
// Usage: configure the breakpoint table through the write port while the block is
// idle: index 0 sets the point count, indexes 1 to 6 set breakpoints 0 to 5 (x in
// bits 31:0, y in bits 63:32). Each sample transaction on i_in then yields exactly
// one result transaction on o_out with the score, the segment and zero span flags
// and the saturated running total after this sample.
// Timing: a sample is taken only while the sequencer is idle, so a new sample is not
// taken until the current one has been through the sequencer. The table scan examines
// the breakpoints one at a time; a sample with no usable segment then goes to the
// result, a zero span pair goes there after the pair fetch, and an interpolated one
// after the pair fetch, the multiply, the divider start and the divider wait.
// Results sit in an output register, so a stalled receiver holds the current
// result and the next sample is still taken; that sample waits in its final state
// until the output register is free. Reset clears the table, the point count, the
// running total and the sequencer, and drops any result not yet taken.
`default_nettype none
`include "piecewise_linear_score_accumulator_macros.svh"

module piecewise_linear_score_accumulator (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_cfg_we,
    input  wire logic [plsa_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  wire logic [plsa_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    plsa_in_if.sink                                    i_in,
    plsa_out_if.source                                 o_out
);

    // Configuration registers.
    logic [plsa_pkg::COUNT_W-1:0]  r_count;
    logic [plsa_pkg::POINT_W-1:0]  r_points [plsa_pkg::MAX_POINTS];

    // Sequencer and working registers.
    plsa_pkg::t_state              r_state;
    plsa_pkg::t_state              n_state;
    logic [plsa_pkg::CNT_W-1:0]    r_idx;
    logic signed [31:0]            r_x;
    logic                          r_clr;
    logic signed [31:0]            r_x0;
    logic signed [31:0]            r_y0;
    logic signed [31:0]            r_dx;
    logic signed [31:0]            r_dy;
    logic signed [31:0]            r_span;
    logic signed [63:0]            r_prod;
    logic signed [31:0]            r_score;
    logic                          r_found;
    logic                          r_zspan;

    // Output register.
    logic                          r_out_valid;
    logic signed [31:0]            r_out_score;
    logic                          r_out_found;
    logic                          r_out_zspan;
    logic signed [31:0]            r_out_sum;

    logic                          in_fire;
    logic                          out_free;
    logic [plsa_pkg::CNT_W-1:0]    eff_count;
    logic [plsa_pkg::POINT_W-1:0]  cur_point;
    logic signed [31:0]            cur_x;
    logic signed [31:0]            cur_y;
    logic                          idx_valid;
    logic                          idx_last;
    logic                          sample_ge;
    logic                          span_zero;
    logic [plsa_pkg::CFG_IDX_W-1:0] cfg_pt;

    logic                          div_start;
    logic                          div_done;
    logic [31:0]                   div_quotient;
    plsa_pkg::t_acc_cmd            acc_cmd;
    logic signed [31:0]            acc_total_next;
    logic                          out_load;

    assign in_fire  = i_in.valid && i_in.ready;
    assign out_free = !r_out_valid || o_out.ready;

    // A count beyond the table depth is clamped to the depth.
    assign eff_count = (r_count > plsa_pkg::COUNT_W'(plsa_pkg::MAX_POINTS))
        ? plsa_pkg::CNT_W'(plsa_pkg::MAX_POINTS)
        : plsa_pkg::CNT_W'(r_count);

    // The table is read at one address per cycle: the scan entry, then its partner.
    assign cur_point = r_points[r_idx[plsa_pkg::PT_IDX_W-1:0]];
    assign cur_x     = cur_point[31:0];
    assign cur_y     = cur_point[63:32];
    assign idx_valid = (r_idx < eff_count);
    assign idx_last  = ((r_idx + plsa_pkg::CNT_W'(1)) >= eff_count);
    assign sample_ge = (r_x >= cur_x);
    assign span_zero = (cur_x == r_x0);

    // Configuration writes; indexes past the table are dropped.
    assign cfg_pt = i_cfg_index - plsa_pkg::REG_POINT_FIRST;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            for (int p = 0; p < plsa_pkg::MAX_POINTS; p++) begin
                r_points[p] <= '0;
            end
        end else if (i_cfg_we) begin
            if (i_cfg_index == plsa_pkg::REG_POINT_COUNT) begin
                r_count <= i_cfg_data[plsa_pkg::COUNT_W-1:0];
            end else if (cfg_pt < plsa_pkg::CFG_IDX_W'(plsa_pkg::MAX_POINTS)) begin
                r_points[cfg_pt[plsa_pkg::PT_IDX_W-1:0]] <= i_cfg_data;
            end
        end
    end

    // Next-state logic of the sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            plsa_pkg::ST_IDLE: begin
                if (in_fire) n_state = plsa_pkg::ST_SCAN;
            end
            plsa_pkg::ST_SCAN: begin
                if (!idx_valid) begin
                    n_state = plsa_pkg::ST_DONE;
                end else if (sample_ge) begin
                    n_state = idx_last ? plsa_pkg::ST_DONE : plsa_pkg::ST_PAIR;
                end
            end
            plsa_pkg::ST_PAIR:  n_state = span_zero ? plsa_pkg::ST_DONE : plsa_pkg::ST_MUL;
            plsa_pkg::ST_MUL:   n_state = plsa_pkg::ST_START;
            plsa_pkg::ST_START: n_state = plsa_pkg::ST_DIV;
            plsa_pkg::ST_DIV: begin
                if (div_done) n_state = plsa_pkg::ST_DONE;
            end
            plsa_pkg::ST_DONE: begin
                if (out_free) n_state = plsa_pkg::ST_IDLE;
            end
            default: n_state = plsa_pkg::ST_IDLE;
        endcase
    end

    // Output decode of the sequencer.
    always_comb begin
        div_start = 1'b0;
        out_load  = 1'b0;
        unique case (r_state)
            plsa_pkg::ST_START: div_start = 1'b1;
            plsa_pkg::ST_DONE:  out_load  = out_free;
            default: begin
                div_start = 1'b0;
                out_load  = 1'b0;
            end
        endcase
    end

    assign i_in.ready    = (r_state == plsa_pkg::ST_IDLE);
    assign acc_cmd.update = out_load;
    assign acc_cmd.clear  = r_clr;
    assign acc_cmd.score  = r_score;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= plsa_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Datapath of one transaction.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            plsa_pkg::ST_IDLE: begin
                if (in_fire) begin
                    r_x     <= i_in.sample_value;
                    r_clr   <= i_in.clear_total;
                    r_idx   <= '0;
                    r_found <= 1'b0;
                    r_zspan <= 1'b0;
                    r_score <= '0;
                end
            end
            plsa_pkg::ST_SCAN: begin
                // A match on the last valid entry leaves the score at zero.
                if (idx_valid && sample_ge && !idx_last) begin
                    r_x0  <= cur_x;
                    r_y0  <= cur_y;
                    r_idx <= r_idx + 1'b1;
                end else if (idx_valid && !sample_ge) begin
                    r_idx <= r_idx + 1'b1;
                end
            end
            plsa_pkg::ST_PAIR: begin
                r_found <= 1'b1;
                r_dx    <= r_x - r_x0;
                r_dy    <= cur_y - r_y0;
                r_span  <= cur_x - r_x0;
                // Equal x on both points: the score is the first point's y.
                if (span_zero) begin
                    r_zspan <= 1'b1;
                    r_score <= r_y0;
                end
            end
            plsa_pkg::ST_MUL: begin
                r_prod <= r_dx * r_dy;
            end
            plsa_pkg::ST_DIV: begin
                if (div_done) r_score <= div_quotient + r_y0;
            end
            default: begin
            end
        endcase
    end

    plsa_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_prod),
        .i_divisor  (r_span),
        .o_done     (div_done),
        .o_quotient (div_quotient)
    );

    plsa_acc u_acc (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (acc_cmd),
        .o_total_next (acc_total_next)
    );

    // Result register toward the receiver.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_score <= r_score;
            r_out_found <= r_found;
            r_out_zspan <= r_zspan;
            r_out_sum   <= acc_total_next;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.score         = r_out_score;
    assign o_out.segment_found = r_out_found;
    assign o_out.zero_span     = r_out_zspan;
    assign o_out.running_sum   = r_out_sum;

    // A zero span result always comes from a found segment.
    `PLSA_ASSERT_NOW(a_zspan_found, i_clk, i_rst_n,
        o_out.valid && o_out.zero_span, o_out.segment_found)
    // Without a segment the score is zero.
    `PLSA_ASSERT_NOW(a_noseg_zero, i_clk, i_rst_n,
        o_out.valid && !o_out.segment_found, o_out.score == 32'sd0)
    // An accepted sample always starts the table scan.
    `PLSA_ASSERT_NEXT(a_accept_scan, i_clk, i_rst_n,
        in_fire, r_state == plsa_pkg::ST_SCAN)
    // The divider finishes only while the sequencer waits for it.
    `PLSA_ASSERT_NOW(a_div_done_wait, i_clk, i_rst_n,
        div_done, r_state == plsa_pkg::ST_DIV)

endmodule

`default_nettype wire
